@@ rtl/core/afsf_pkg.sv @@
// ---------------------------------------------------------------------------
// afsf_pkg : shared types and constants of the ARMA feature smoothing filter
// Filter order, fixed-point widths, divide-by-constant reciprocal and the
// job word that travels from the front end to the back end.
// ---------------------------------------------------------------------------
package afsf_pkg;

   // filter order M and the averaging divisor 2M+1
   localparam int ORDER    = 2;
   localparam int DIVISOR  = 2 * ORDER + 1;

   // Q7.16 sample width
   localparam int SAMPLE_W = 24;

   // accumulator holds a sum of 2M+1 samples
   localparam int DIV_LOG  = $clog2(DIVISOR);
   localparam int ACC_W    = SAMPLE_W + DIV_LOG;
   localparam int MAG_W    = ACC_W - 1;

   // floor(mag / DIVISOR) == (mag * RECIP) >> RECIP_SHIFT for any MAG_W-bit mag
   localparam int RECIP_SHIFT = MAG_W + DIV_LOG;
   localparam int RECIP_W     = MAG_W + 1;
   localparam int PROD_W      = MAG_W + RECIP_W;
   localparam longint unsigned RECIP =
      ((64'd1 << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;

   // frame counter saturates at 2M
   localparam int COUNT_W  = $clog2(2 * ORDER + 1);
   // index into the copy tail of a job
   localparam int IDX_W    = (ORDER > 1) ? $clog2(ORDER) : 1;

   // front-to-back job queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [ACC_W-1:0]    acc_type;

   typedef enum logic [1:0] {
      JOB_PASS,    // pass the sample through, record it in the history
      JOB_FILTER,  // produce a filtered frame, copies follow when last
      JOB_COPY     // emit copies of the look-ahead frames only
   } job_kind_type;

   typedef struct packed {
      job_kind_type                   kind;
      logic                           last;
      sample_type                     value;
      acc_type                        window_sum;
      logic [ORDER-1:0][SAMPLE_W-1:0] tail;       // newest M samples, oldest at 0
      logic [IDX_W-1:0]               copy_start;
   } job_type;

   // sign-extend a sample to accumulator width
   function automatic acc_type widen(input sample_type v);
      widen = ACC_W'(v);
   endfunction

endpackage

@@ rtl/core/afsf_req_if.sv @@
// ---------------------------------------------------------------------------
// afsf_req_if : sample channel
// Valid/ready channel carrying one feature sample word per transfer.
// ---------------------------------------------------------------------------
interface afsf_req_if;
   logic                     valid;
   logic                     ready;
   afsf_pkg::sample_type     sample;
   logic                     last_frame;

   modport source (output valid, output sample, output last_frame, input ready);
   modport sink   (input valid, input sample, input last_frame, output ready);
endinterface

@@ rtl/core/afsf_rsp_if.sv @@
// ---------------------------------------------------------------------------
// afsf_rsp_if : result channel
// Valid/ready channel carrying one smoothed frame word per transfer.
// ---------------------------------------------------------------------------
interface afsf_rsp_if;
   logic                     valid;
   logic                     ready;
   afsf_pkg::sample_type     smoothed_value;
   logic                     was_filtered;
   logic                     last_result;

   modport source (output valid, output smoothed_value, output was_filtered,
                   output last_result, input ready);
   modport sink   (input valid, input smoothed_value, input was_filtered,
                   input last_result, output ready);
endinterface

@@ rtl/core/arma_feature_smoothing_filter.sv @@
// ---------------------------------------------------------------------------
// arma_feature_smoothing_filter : ARMA smoothing of one feature dimension
// Frames pass through until M are seen, then each frame is averaged with the
// last M outputs and M look-ahead samples; the last frame flushes the rest.
//
//   channel  | dir | word fields                                  | handshake
//   ---------+-----+----------------------------------------------+----------
//   req_if   | in  | sample[23:0] (Q7.16), last_frame             | valid/ready
//   rsp_if   | out | smoothed_value[23:0], was_filtered, last_result | valid/ready
//
// One sample word per cycle sustained while the job queue has room; the back
// end loop (history sum add, reciprocal multiply, history update) is all
// combinational. A last word whose frame is filtered yields ORDER+1 result
// words from the single result register; a short-utterance flush yields up
// to ORDER words, one per cycle while the result channel is ready.
// Synchronous reset clears all but the result payload and queue entries.
// A two-entry job queue lets the input keep flowing while results stall.
// ---------------------------------------------------------------------------
module arma_feature_smoothing_filter (
   input  logic        clock,
   input  logic        reset,
   afsf_req_if.sink    req_if,
   afsf_rsp_if.source  rsp_if
);
   import afsf_pkg::*;

   job_type push_job, head_job;
   logic    job_push, job_pop, head_valid, queue_full;

   // intake and classification
   afsf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .queue_full (queue_full),
      .job_push   (job_push),
      .job_out    (push_job)
   );

   // decoupling queue
   afsf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (push_job),
      .pop        (job_pop),
      .head_valid (head_valid),
      .head_job   (head_job),
      .full       (queue_full)
   );

   // filter datapath and result word
   afsf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (head_valid),
      .job       (head_job),
      .job_pop   (job_pop),
      .rsp_if    (rsp_if)
   );

endmodule

@@ rtl/core/afsf_front.sv @@
// ---------------------------------------------------------------------------
// afsf_front : sample intake and classification
// Keeps the look-ahead window, its running sum and the frame count, and turns
// each accepted word into a job for the back end.
// ---------------------------------------------------------------------------
module afsf_front (
   input  logic              clock,
   input  logic              reset,
   afsf_req_if.sink          req_if,
   input  logic              queue_full,
   output logic              job_push,
   output afsf_pkg::job_type job_out
);
   import afsf_pkg::*;

   sample_type         window_ff [ORDER+1];
   sample_type         window_in [ORDER+1];
   acc_type            window_sum_ff, window_sum_in;
   logic [COUNT_W-1:0] frames_seen_ff, frames_seen_in;
   logic [COUNT_W-1:0] start_wide;
   logic               accept;

   assign req_if.ready = !queue_full;
   assign accept       = req_if.valid && req_if.ready;

   // window after shifting in the new sample
   always_comb begin
      for (int i = 0; i < ORDER; i++) begin
         window_in[i] = window_ff[i+1];
      end
      window_in[ORDER] = req_if.sample;
   end

   // running sum of the window: drop the oldest, add the newest
   assign window_sum_in = window_sum_ff - widen(window_ff[0]) + widen(req_if.sample);

   // frame count, saturating at 2M
   assign frames_seen_in = (frames_seen_ff < COUNT_W'(2 * ORDER)) ?
                           frames_seen_ff + COUNT_W'(1) : frames_seen_ff;

   // first copy of a short utterance is frame M, at tail index 2M-n-1
   assign start_wide = COUNT_W'(2 * ORDER - 1) - frames_seen_ff;

   // classify the word
   always_comb begin
      job_out.value      = req_if.sample;
      job_out.last       = req_if.last_frame;
      job_out.window_sum = window_sum_in;
      for (int i = 0; i < ORDER; i++) begin
         job_out.tail[i] = window_in[i+1];
      end
      job_out.copy_start = '0;
      job_out.kind       = JOB_FILTER;
      job_push           = accept;
      if (frames_seen_ff < COUNT_W'(ORDER)) begin
         job_out.kind = JOB_PASS;
      end else if (frames_seen_ff < COUNT_W'(2 * ORDER)) begin
         job_out.kind       = JOB_COPY;
         job_out.copy_start = start_wide[IDX_W-1:0];
         // collecting look-ahead: nothing to do unless the utterance ends
         job_push           = accept && req_if.last_frame;
      end
   end

   // state registers; the last frame returns everything to reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= ORDER; i++) begin
            window_ff[i] <= '0;
         end
         window_sum_ff  <= '0;
         frames_seen_ff <= '0;
      end else if (accept) begin
         if (req_if.last_frame) begin
            for (int i = 0; i <= ORDER; i++) begin
               window_ff[i] <= '0;
            end
            window_sum_ff  <= '0;
            frames_seen_ff <= '0;
         end else begin
            window_ff      <= window_in;
            window_sum_ff  <= window_sum_in;
            frames_seen_ff <= frames_seen_in;
         end
      end
   end

endmodule

@@ rtl/core/afsf_queue.sv @@
// ---------------------------------------------------------------------------
// afsf_queue : job queue between front and back end
// Two-entry register queue; push and pop may happen in the same cycle.
// ---------------------------------------------------------------------------
module afsf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  afsf_pkg::job_type push_job,
   input  logic              pop,
   output logic              head_valid,
   output afsf_pkg::job_type head_job,
   output logic              full
);
   import afsf_pkg::*;

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   // payload store
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

@@ rtl/core/afsf_back.sv @@
// ---------------------------------------------------------------------------
// afsf_back : filter datapath and result register
// Holds the output history and its sum, computes the filtered frame with a
// reciprocal multiply, sequences edge-frame copies and drives the result word.
// ---------------------------------------------------------------------------
module afsf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  afsf_pkg::job_type job,
   output logic              job_pop,
   afsf_rsp_if.source        rsp_if
);
   import afsf_pkg::*;

   typedef enum logic {ST_RUN, ST_COPY} state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   copy_idx_ff, copy_idx_in;
   sample_type         hist_ff [ORDER];
   sample_type         hist_in [ORDER];
   acc_type            hist_sum_ff, hist_sum_in;
   logic               rsp_valid_ff, rsp_valid_in;
   sample_type         value_ff, value_in;
   logic               filt_ff, filt_in;
   logic               last_ff, last_in;

   logic               can_load;
   acc_type            acc, acc_neg;
   logic               neg;
   logic [MAG_W-1:0]   mag;
   logic [PROD_W-1:0]  prod;
   logic [SAMPLE_W-1:0] quot;
   sample_type         filt_val;
   logic               hist_push, hist_clear;
   sample_type         push_val;
   logic [IDX_W-1:0]   sel_idx;
   logic               sel_is_end;

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.smoothed_value = value_ff;
   assign rsp_if.was_filtered   = filt_ff;
   assign rsp_if.last_result    = last_ff;

   // result register is free or being emptied this cycle
   assign can_load = !rsp_valid_ff || rsp_if.ready;

   // filtered frame: (history sum + window sum) / (2M+1), toward zero
   assign acc      = hist_sum_ff + job.window_sum;
   assign neg      = acc[ACC_W-1];
   assign acc_neg  = -acc;
   assign mag      = neg ? acc_neg[MAG_W-1:0] : acc[MAG_W-1:0];
   assign prod     = PROD_W'(mag) * PROD_W'(RECIP);
   assign quot     = prod[RECIP_SHIFT +: SAMPLE_W];
   assign filt_val = neg ? sample_type'(-quot) : sample_type'(quot);

   // copy index: job start on the first copy, counter afterwards
   assign sel_idx    = (state_ff == ST_COPY) ? copy_idx_ff : job.copy_start;
   assign sel_is_end = (sel_idx == IDX_W'(ORDER - 1));

   // next-state and datapath selection
   always_comb begin
      state_in     = state_ff;
      copy_idx_in  = copy_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      value_in     = value_ff;
      filt_in      = filt_ff;
      last_in      = last_ff;
      job_pop      = 1'b0;
      hist_push    = 1'b0;
      hist_clear   = 1'b0;
      push_val     = job.value;
      case (state_ff)
         ST_RUN: begin
            if (can_load && job_valid) begin
               hist_clear = job.last;
               case (job.kind)
                  JOB_PASS: begin
                     rsp_valid_in = 1'b1;
                     value_in     = job.value;
                     filt_in      = 1'b0;
                     last_in      = job.last;
                     hist_push    = 1'b1;
                     job_pop      = 1'b1;
                  end
                  JOB_FILTER: begin
                     rsp_valid_in = 1'b1;
                     value_in     = filt_val;
                     filt_in      = 1'b1;
                     last_in      = 1'b0;
                     hist_push    = 1'b1;
                     push_val     = filt_val;
                     if (job.last) begin
                        state_in    = ST_COPY;
                        copy_idx_in = '0;
                     end else begin
                        job_pop = 1'b1;
                     end
                  end
                  JOB_COPY: begin
                     rsp_valid_in = 1'b1;
                     value_in     = job.tail[sel_idx];
                     filt_in      = 1'b0;
                     last_in      = sel_is_end;
                     if (sel_is_end) begin
                        job_pop = 1'b1;
                     end else begin
                        state_in    = ST_COPY;
                        copy_idx_in = sel_idx + IDX_W'(1);
                     end
                  end
                  default: begin
                     job_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_COPY: begin
            // trailing copies of the look-ahead frames
            if (can_load) begin
               rsp_valid_in = 1'b1;
               value_in     = job.tail[sel_idx];
               filt_in      = 1'b0;
               last_in      = sel_is_end;
               if (sel_is_end) begin
                  job_pop  = 1'b1;
                  state_in = ST_RUN;
               end else begin
                  copy_idx_in = sel_idx + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   // history shift line: oldest at 0, running sum follows it
   always_comb begin
      for (int i = 0; i < ORDER - 1; i++) begin
         hist_in[i] = hist_ff[i+1];
      end
      hist_in[ORDER-1] = push_val;
      hist_sum_in      = hist_sum_ff - widen(hist_ff[0]) + widen(push_val);
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         copy_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         hist_sum_ff  <= '0;
         for (int i = 0; i < ORDER; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         copy_idx_ff  <= copy_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         value_ff     <= value_in;
         filt_ff      <= filt_in;
         last_ff      <= last_in;
         if (hist_clear) begin
            hist_sum_ff <= '0;
            for (int i = 0; i < ORDER; i++) begin
               hist_ff[i] <= '0;
            end
         end else if (hist_push) begin
            hist_sum_ff <= hist_sum_in;
            hist_ff     <= hist_in;
         end
      end
   end

   // a job is only retired when one is present
   assert property (@(posedge clock) disable iff (reset) job_pop |-> job_valid)
      else $error("afsf_back: job popped from an empty queue");

   // copying works on the job still held at the queue head
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == ST_COPY) |-> job_valid)
      else $error("afsf_back: copy sequence without a held job");

   // a filtered word never closes an utterance
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid_ff && filt_ff) |-> !last_ff)
      else $error("afsf_back: filtered word marked last");

   // leaving the copy sequence always emits the closing word
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == ST_COPY && state_in == ST_RUN) |=>
                    (rsp_valid_ff && last_ff))
      else $error("afsf_back: copy sequence ended without a last word");

endmodule
